// ----- design/sgd_linear_regression_trainer_unit_assert.svh -----
// Assertion macros for the trainer RTL.
`ifndef SGD_LINEAR_REGRESSION_TRAINER_UNIT_ASSERT_SVH
`define SGD_LINEAR_REGRESSION_TRAINER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SGDLR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sgdlr assertion failed");

// Next-cycle implication, checked out of reset.
`define SGDLR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sgdlr assertion failed");

`endif

// ----- design/sgdlr_pkg.sv -----
`default_nettype none
package sgdlr_pkg;

  localparam int NUM_FEATURES = 8;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_BATCH    = 256;
  localparam int NW           = NUM_FEATURES + 1;
  localparam int DIV_RADIX    = 4;
  localparam int DIV_STEPS    = 48 / DIV_RADIX;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  // Function codes
  localparam logic [1:0] FN_LOAD    = 2'd0;
  localparam logic [1:0] FN_TRAIN   = 2'd1;
  localparam logic [1:0] FN_PREDICT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_STEP_RATE = 2'd0;
  localparam logic [1:0] CFG_DECAY     = 2'd1;
  localparam logic [1:0] CFG_BATCH     = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] feature_0;
    logic signed [31:0] feature_1;
    logic signed [31:0] feature_2;
    logic signed [31:0] feature_3;
    logic signed [31:0] feature_4;
    logic signed [31:0] feature_5;
    logic signed [31:0] feature_6;
    logic signed [31:0] feature_7;
    logic signed [31:0] target_value;
    logic [3:0]         weight_slot;
    logic signed [31:0] weight_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] prediction;
    logic               batch_done;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUM1, ST_SUM2, ST_ERR, ST_GMUL, ST_DIV, ST_ACC,
    ST_UPD1, ST_UPD2, ST_UPD3, ST_UPD4, ST_DONE
  } state_e;

  typedef struct packed {
    logic pmul;
    logic gmul;
    logic div_step;
    logic acc;
    logic upd_reg;
    logic upd_sum;
    logic upd_mul;
    logic upd_wr;
  } lane_ctrl_t;

  typedef struct packed {
    logic sum1;
    logic sum2;
  } merge_ctrl_t;

  // Signed 32x32 product, truncated toward zero by FRAC_BITS
  function automatic logic signed [47:0] mulq_32x32(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [47:0] r;
    ma = a[31] ? (~a + 32'd1) : a;
    mb = b[31] ? (~b + 32'd1) : b;
    p  = ma * mb;
    r  = {1'b0, p[FRAC_BITS +: 47]};
    return (a[31] != b[31]) ? -$signed(r) : $signed(r);
  endfunction

  // Unsigned 17-bit factor times signed 32-bit weight
  function automatic logic signed [33:0] mulq_17x32(logic [16:0] a,
                                                    logic signed [31:0] b);
    logic [31:0] mb;
    logic [48:0] p;
    logic [33:0] r;
    mb = b[31] ? (~b + 32'd1) : b;
    p  = a * mb;
    r  = {1'b0, p[FRAC_BITS +: 33]};
    return b[31] ? -$signed(r) : $signed(r);
  endfunction

  // Unsigned 17-bit rate times signed 48-bit sum
  function automatic logic signed [48:0] mulq_17x48(logic [16:0] a,
                                                    logic signed [47:0] b);
    logic [47:0] mb;
    logic [64:0] p;
    logic [48:0] r;
    mb = b[47] ? (~b + 48'd1) : b;
    p  = a * mb;
    r  = {1'b0, p[FRAC_BITS +: 48]};
    return b[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [47:0] sat_acc(logic signed [49:0] v);
    if (v > 50'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -50'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  function automatic logic signed [31:0] sat_w(logic signed [51:0] v);
    if (v > 52'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -52'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/sgdlr_lane.sv -----
`default_nettype none
module sgdlr_lane
  import sgdlr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lane_ctrl_t         ctrl_i,
  input  wire logic               load_i,
  input  wire logic signed [31:0] load_val_i,
  input  wire logic signed [31:0] x_i,
  input  wire logic signed [31:0] err_i,
  input  wire logic [8:0]         batch_i,
  input  wire logic [16:0]        rate_i,
  input  wire logic [16:0]        decay_i,
  output logic signed [47:0]      prod_o
);

  logic signed [31:0] w_q;
  logic signed [47:0] g_q;
  logic signed [47:0] prod_q;
  logic [47:0]        quo_q, quo_d;
  logic [8:0]         rem_q, rem_d;
  logic               neg_q;
  logic signed [33:0] reg_q;
  logic signed [47:0] s_q;
  logic signed [48:0] upd_q;
  logic signed [47:0] gprod;
  logic signed [47:0] q_signed;

  assign prod_o = prod_q;
  assign gprod  = mulq_32x32(x_i, err_i);
  assign q_signed = neg_q ? -$signed(quo_q) : $signed(quo_q);

  // Radix-16 restoring divide step: four quotient bits per cycle
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < DIV_RADIX; k++) begin
      rem_d = {rem_d[7:0], quo_d[47]};
      quo_d = {quo_d[46:0], 1'b0};
      if (rem_d >= batch_i) begin
        rem_d    = rem_d - batch_i;
        quo_d[0] = 1'b1;
      end
    end
  end

  // Hold weight and gradient accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= '0;
      g_q <= '0;
    end else begin
      if (load_i) w_q <= load_val_i;
      else if (ctrl_i.upd_wr) w_q <= sat_w(52'(w_q) - 52'(upd_q));
      if (ctrl_i.acc) g_q <= sat_acc(50'(g_q) + 50'(q_signed));
      else if (ctrl_i.upd_wr) g_q <= '0;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (ctrl_i.pmul) prod_q <= mulq_32x32(w_q, x_i);
    if (ctrl_i.gmul) begin
      quo_q <= gprod[47] ? 48'(-gprod) : 48'(gprod);
      neg_q <= gprod[47];
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (ctrl_i.upd_reg) reg_q <= mulq_17x32(decay_i, w_q);
    if (ctrl_i.upd_sum) s_q <= sat_acc(50'(g_q) + 50'(reg_q));
    if (ctrl_i.upd_mul) upd_q <= mulq_17x48(rate_i, s_q);
  end

endmodule
`default_nettype wire

// ----- design/sgdlr_merge.sv -----
`default_nettype none
module sgdlr_merge
  import sgdlr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire merge_ctrl_t        ctrl_i,
  input  wire logic signed [47:0] prod_i [NW],
  output logic signed [31:0]      pred_o
);

  localparam int GROUPS = (NW + 2) / 3;

  logic signed [51:0] part_q [GROUPS];
  logic signed [51:0] part_d [GROUPS];
  logic signed [51:0] total;
  logic signed [31:0] pred_q;

  assign pred_o = pred_q;

  // Sum lane products in groups of three
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      part_d[g] = '0;
      for (int k = 0; k < 3; k++) begin
        if (g * 3 + k < NW) part_d[g] = part_d[g] + 52'(prod_i[g * 3 + k]);
      end
    end
    total = '0;
    for (int g = 0; g < GROUPS; g++) total = total + part_q[g];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum1) part_q <= part_d;
    if (ctrl_i.sum2) pred_q <= sat_w(total);
  end

endmodule
`default_nettype wire

// ----- design/sgd_linear_regression_trainer_unit.sv -----
// Mini-batch SGD linear regression trainer, signed Q16.16. Nine lanes (bias
// plus eight features) each hold one weight and one gradient accumulator and
// work side by side; a two-stage adder tree merges the lane products into the
// prediction. One item at a time: a load goes straight to the result; a predict
// runs the lane products and both adder stages; a training sample adds the error,
// gradient product, divide and accumulate, and the weight update when it closes a
// batch. The per-lane divide by batch size retires four quotient bits per cycle.
// A result may wait in the output register while the next item is taken in.
`default_nettype none
`include "sgd_linear_regression_trainer_unit_assert.svh"
module sgd_linear_regression_trainer_unit
  import sgdlr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_beat_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_beat_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [16:0] rate_q, decay_q;
  logic [8:0]  spb_q, eff_b;
  logic [8:0]  cnt_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic signed [31:0] feat_q [NUM_FEATURES];
  logic signed [31:0] x_lane [NW];
  logic signed [31:0] target_q, err_q;
  logic [1:0]  func_q;
  logic        done_q;
  logic signed [47:0] prod [NW];
  logic signed [31:0] pred;
  logic        accept, out_free, last_of_batch;
  lane_ctrl_t  lctrl;
  merge_ctrl_t mctrl;
  out_beat_t   out_q;
  logic        out_valid_q;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign last_of_batch = (cnt_q + 9'd1) >= eff_b;

  // Clamp batch size to 1..MAX_BATCH
  always_comb begin
    eff_b = spb_q;
    if (spb_q == '0) eff_b = 9'd1;
    else if (32'(spb_q) > MAX_BATCH) eff_b = 9'(MAX_BATCH);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        state_d = (in_data_i.func == FN_TRAIN || in_data_i.func == FN_PREDICT)
                  ? ST_MUL : ST_DONE;
      end
      ST_MUL:  state_d = ST_SUM1;
      ST_SUM1: state_d = ST_SUM2;
      ST_SUM2: state_d = (func_q == FN_TRAIN) ? ST_ERR : ST_DONE;
      ST_ERR:  state_d = ST_GMUL;
      ST_GMUL: state_d = ST_DIV;
      ST_DIV:  if (32'(div_cnt_q) == DIV_STEPS - 1) state_d = ST_ACC;
      ST_ACC:  state_d = last_of_batch ? ST_UPD1 : ST_DONE;
      ST_UPD1: state_d = ST_UPD2;
      ST_UPD2: state_d = ST_UPD3;
      ST_UPD3: state_d = ST_UPD4;
      ST_UPD4: state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    lctrl      = '0;
    mctrl      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_MUL:  lctrl.pmul = 1'b1;
      ST_SUM1: mctrl.sum1 = 1'b1;
      ST_SUM2: mctrl.sum2 = 1'b1;
      ST_GMUL: lctrl.gmul = 1'b1;
      ST_DIV:  lctrl.div_step = 1'b1;
      ST_ACC:  lctrl.acc = 1'b1;
      ST_UPD1: lctrl.upd_reg = 1'b1;
      ST_UPD2: lctrl.upd_sum = 1'b1;
      ST_UPD3: lctrl.upd_mul = 1'b1;
      ST_UPD4: lctrl.upd_wr = 1'b1;
      default: ;
    endcase
  end

  assign x_lane[0] = 32'sd1 <<< FRAC_BITS;
  for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_x
    assign x_lane[k + 1] = feat_q[k];
  end

  for (genvar k = 0; k < NW; k++) begin : g_lane
    sgdlr_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (lctrl),
      .load_i     (accept && in_data_i.func == FN_LOAD &&
                   32'(in_data_i.weight_slot) == k),
      .load_val_i (in_data_i.weight_value),
      .x_i        (x_lane[k]),
      .err_i      (err_q),
      .batch_i    (eff_b),
      .rate_i     (rate_q),
      .decay_i    (decay_q),
      .prod_o     (prod[k])
    );
  end

  sgdlr_merge u_merge (
    .clk_i  (clk_i),
    .ctrl_i (mctrl),
    .prod_i (prod),
    .pred_o (pred)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rate_q      <= 17'd655;
      decay_q     <= '0;
      spb_q       <= 9'd32;
      cnt_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      func_q      <= FN_LOAD;
      done_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_RATE: rate_q  <= cfg_data_i;
          CFG_DECAY:     decay_q <= cfg_data_i;
          CFG_BATCH:     spb_q   <= cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (accept) begin
        func_q <= in_data_i.func;
        done_q <= 1'b0;
      end
      if (state_q == ST_GMUL) div_cnt_q <= '0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + 1'b1;
      if (state_q == ST_ACC) cnt_q <= cnt_q + 9'd1;
      if (state_q == ST_UPD4) begin
        cnt_q  <= '0;
        done_q <= 1'b1;
      end
      // Refill from the finished item, else drop the beat once taken
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      feat_q[0] <= in_data_i.feature_0;
      feat_q[1] <= in_data_i.feature_1;
      feat_q[2] <= in_data_i.feature_2;
      feat_q[3] <= in_data_i.feature_3;
      feat_q[4] <= in_data_i.feature_4;
      feat_q[5] <= in_data_i.feature_5;
      feat_q[6] <= in_data_i.feature_6;
      feat_q[7] <= in_data_i.feature_7;
      target_q  <= in_data_i.target_value;
    end
    if (state_q == ST_ERR) err_q <= sat_w(52'(pred) - 52'(target_q));
    if (state_q == ST_DONE && out_free) begin
      out_q.prediction <= (func_q == FN_TRAIN || func_q == FN_PREDICT) ? pred : '0;
      out_q.batch_done <= done_q;
    end
  end

  `SGDLR_ASSERT_NEXT(a_upd_clears_count, state_q == ST_UPD4, cnt_q == '0)
  `SGDLR_ASSERT_NEXT(a_done_holds_when_full,
                     state_q == ST_DONE && out_valid_q && out_stall_i,
                     state_q == ST_DONE)
  `SGDLR_ASSERT_NOW(a_div_count_range, state_q == ST_DIV,
                    32'(div_cnt_q) < DIV_STEPS)

endmodule
`default_nettype wire

// ----- tb/tb_sgd_linear_regression_trainer_unit_checker.sv -----
`default_nettype none
module tb_sgd_linear_regression_trainer_unit_checker
  import sgdlr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire in_beat_t    in_data_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire out_beat_t   out_data_i,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i,
  output int               pending_o,
  output int               fail_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sh7FFF_FFFF;
  localparam longint WMIN = -WMAX - 1;
  localparam longint GMAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint GMIN = -GMAX - 1;

  // trainer state mirrored here
  longint      weights[NW];
  longint      grad_acc[NW];
  int unsigned samples_seen;
  longint      rate, decay, batch_reg;

  out_beat_t   expected_q[$];
  int          fails;

  assign pending_o  = expected_q.size();
  assign fail_cnt_o = fails;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // exact product of magnitudes, truncated toward zero
  function automatic longint fix_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    p  = (ma * mb) >> FRAC_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < NW; i++) begin
      weights[i]  = 0;
      grad_acc[i] = 0;
    end
    samples_seen = 0;
    rate         = 655;
    decay        = 0;
    batch_reg    = 32;
  endfunction

  // apply one beat to the mirrored state and return the expected result
  function automatic out_beat_t train_step(in_beat_t d);
    out_beat_t   r;
    longint      x[NW];
    longint      sum, pred, err, t, q, s, w;
    longint unsigned bsz;
    r = '0;
    if (d.func == FN_LOAD) begin
      if (d.weight_slot < NW) weights[d.weight_slot] = longint'(d.weight_value);
    end else if (d.func == FN_TRAIN || d.func == FN_PREDICT) begin
      x[0] = longint'(1) << FRAC_BITS;
      x[1] = d.feature_0; x[2] = d.feature_1; x[3] = d.feature_2;
      x[4] = d.feature_3; x[5] = d.feature_4; x[6] = d.feature_5;
      x[7] = d.feature_6; x[8] = d.feature_7;
      sum = weights[0];
      for (int i = 1; i < NW; i++) sum += fix_mul(weights[i], x[i]);
      pred = clamp(sum, WMIN, WMAX);
      r.prediction = pred[31:0];
      if (d.func == FN_TRAIN) begin
        bsz = (batch_reg == 0) ? 1 : ((batch_reg > MAX_BATCH) ? MAX_BATCH : batch_reg);
        err = clamp(pred - longint'(d.target_value), WMIN, WMAX);
        for (int i = 0; i < NW; i++) begin
          t = fix_mul(x[i], err);
          q = longint'(((t < 0) ? longint'(-t) : t) / bsz);
          if (t < 0) q = -q;
          grad_acc[i] = clamp(grad_acc[i] + q, GMIN, GMAX);
        end
        samples_seen++;
        if (samples_seen >= bsz) begin
          for (int i = 0; i < NW; i++) begin
            w           = weights[i];
            s           = clamp(grad_acc[i] + fix_mul(decay, w), GMIN, GMAX);
            weights[i]  = clamp(w - fix_mul(rate, s), WMIN, WMAX);
            grad_acc[i] = 0;
          end
          samples_seen = 0;
          r.batch_done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  initial begin
    fails = 0;
    clear_state();
  end

  // track config, predict on input beats, compare on output beats
  always @(posedge clk_i) begin
    out_beat_t e;
    if (!rst_ni) begin
      clear_state();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_RATE: rate      = cfg_data_i;
          CFG_DECAY:     decay     = cfg_data_i;
          CFG_BATCH:     batch_reg = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected: prediction %0d", out_data_i.prediction);
          fails++;
        end else begin
          e = expected_q.pop_front();
          if (out_data_i.prediction !== e.prediction) begin
            $error("prediction: expected %0d, actual %0d", e.prediction,
                   out_data_i.prediction);
            fails++;
          end
          if (out_data_i.batch_done !== e.batch_done) begin
            $error("batch_done: expected %0d, actual %0d", e.batch_done,
                   out_data_i.batch_done);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q.push_back(train_step(in_data_i));
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_sgd_linear_regression_trainer_unit.sv -----
`default_nettype none
module tb_sgd_linear_regression_trainer_unit;
  import sgdlr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_STEP_RATE;
  logic [16:0] cfg_data = '0;
  int          pending, fail_cnt;
  logic        in_took = 1'b0, out_took = 1'b0;
  logic        hold_req = 1'b0;
  logic        calm = 1'b0;

  always #6 clk_i = ~clk_i;

  sgd_linear_regression_trainer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  tb_sgd_linear_regression_trainer_unit_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .pending_o(pending), .fail_cnt_o(fail_cnt)
  );

  // record handshakes at the edge for the driver and the watchdog
  always @(posedge clk_i) begin
    in_took  <= in_valid && !in_stall;
    out_took <= out_valid && !out_stall;
  end

  // abort when nothing moves for too long
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(negedge clk_i);
      idle = (in_took || out_took) ? 0 : idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("** sgd_linear_regression_trainer_unit: FAILED **");
        $finish;
      end
    end
  end

  // receiver: random stalls, occasional stretches, one long hold-off on request
  initial begin
    int stretch;
    stretch = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) stretch = 400;
      else if (stretch == 0 && !calm && $urandom_range(0, 99) < 2)
        stretch = $urandom_range(15, 60);
      if (stretch > 0) begin
        stretch--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
      end
    end
  end

  function automatic logic signed [31:0] rand_val();
    case ($urandom_range(0, 9))
      0:       return 32'(signed'($urandom()));
      1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic in_beat_t rand_item();
    in_beat_t d;
    int       pick;
    d = '0;
    pick = $urandom_range(0, 99);
    d.func = (pick < 10) ? FN_LOAD : (pick < 80) ? FN_TRAIN :
             (pick < 95) ? FN_PREDICT : FN_UNUSED;
    d.feature_0 = rand_val(); d.feature_1 = rand_val();
    d.feature_2 = rand_val(); d.feature_3 = rand_val();
    d.feature_4 = rand_val(); d.feature_5 = rand_val();
    d.feature_6 = rand_val(); d.feature_7 = rand_val();
    d.target_value = rand_val();
    d.weight_slot  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
    d.weight_value = rand_val();
    return d;
  endfunction

  // offer one beat after a random gap, hold it until taken
  task automatic send(in_beat_t d, bit no_gap);
    int gap;
    gap = 0;
    if (!no_gap && !calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = $urandom_range(1, 3);
        3:       gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    do @(negedge clk_i); while (!in_took);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_w(logic [3:0] slot, logic signed [31:0] val);
    in_beat_t d;
    d = '0;
    d.func = FN_LOAD;
    d.weight_slot = slot;
    d.weight_value = val;
    send(d, 1'b0);
  endtask

  initial begin
    in_beat_t    d;
    logic [16:0] rates[6], decays[6], batches[6];
    rates   = '{17'd655, 17'd65536, 17'd0, 17'h1FFFF, 17'd3000, 17'd20000};
    decays  = '{17'd0, 17'd65536, 17'd0, 17'h1FFFF, 17'd1000, 17'd300};
    batches = '{17'd32, 17'd1, 17'd256, 17'd0, 17'd511, 17'd4};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: loads of every slot, ignored slots, extremes, each function
    for (int s = 0; s < NW; s++)
      load_w(4'(s), (s % 2) ? 32'sh0001_0000 : -32'sh0000_8000);
    load_w(4'd9, 32'sh1234_5678);
    load_w(4'd15, 32'sh8000_0000);
    d = '0;
    d.func = FN_PREDICT;
    d.feature_0 = 32'sh7FFF_FFFF; d.feature_1 = 32'sh8000_0000;
    send(d, 1'b0);
    d.func = FN_UNUSED;
    d.target_value = 32'sh7FFF_FFFF;
    send(d, 1'b0);
    load_w(4'd0, 32'sh7FFF_FFFF);
    load_w(4'd1, 32'sh7FFF_FFFF);
    d = '0;
    d.func = FN_TRAIN;
    d.feature_0 = 32'sh7FFF_FFFF;
    d.target_value = 32'sh8000_0000;
    send(d, 1'b0);
    load_w(4'd1, 32'sh8000_0000);
    d.feature_0 = 32'sh7FFF_FFFF;
    d.target_value = 32'sh7FFF_FFFF;
    send(d, 1'b0);
    d = '1;
    d.func = FN_TRAIN;
    send(d, 1'b0);
    d.func = FN_PREDICT;
    send(d, 1'b0);
    drain();

    // phases with different settings; full batches reach the weight update
    for (int p = 0; p < 6; p++) begin
      cfg_write(CFG_STEP_RATE, rates[p]);
      cfg_write(CFG_DECAY, decays[p]);
      cfg_write(CFG_BATCH, batches[p]);
      for (int s = 0; s < NW; s++)
        load_w(4'(s), 32'($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
      if (p == 2) begin
        // hold the result side off while beats keep coming
        hold_req <= 1'b1;
        @(negedge clk_i);
        hold_req <= 1'b0;
        for (int i = 0; i < 20; i++) send(rand_item(), 1'b1);
      end
      if (p == 4) calm <= 1'b1;
      for (int i = 0; i < 150; i++) send(rand_item(), 1'b0);
      calm <= 1'b0;
      drain();
    end

    if (fail_cnt == 0) begin
      $display("** sgd_linear_regression_trainer_unit: PASSED **");
    end else begin
      $display("** sgd_linear_regression_trainer_unit: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
